>>> design/randomized_set_table_core_assert.svh
// Assertion macros for the checker file of the randomized set table.
// No dependencies; include by bare file name.
`ifndef RANDOMIZED_SET_TABLE_CORE_ASSERT_SVH
`define RANDOMIZED_SET_TABLE_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define RST_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("randomized_set_table_core: check failed");

// Next-cycle implication, sampled on clk, off during reset.
`define RST_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("randomized_set_table_core: check failed");

`endif

>>> design/rst_pkg.sv
// Shared types and codes for the randomized set table.
// No dependencies; used by every module of the block.
package rst_pkg;

    localparam int WORD_W = 32;
    localparam int STEP_W = $clog2(WORD_W);
    localparam int REQ_W  = 2;
    localparam int ST_W   = 2;

    localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
    localparam logic [REQ_W-1:0] REQ_REMOVE = 2'd1;
    localparam logic [REQ_W-1:0] REQ_GET    = 2'd2;

    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_MISS  = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL  = 2'd2;
    localparam logic [ST_W-1:0] ST_EMPTY = 2'd3;

    // Token that walks the cell chain: search key plus collected results.
    typedef struct packed {
        logic              vld;
        logic              hit;
        logic [WORD_W-1:0] key;
        logic [WORD_W-1:0] data;
    } tok_t;

endpackage

>>> design/rst_cell.sv
// One storage cell of the set table chain: holds one entry, compares and
// fetches as the token passes. Depends on rst_pkg.
module rst_cell #(
    parameter int CAPACITY = 64,
    parameter int IDX      = 0
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  rst_pkg::tok_t                  tok_in,
    input  logic [$clog2(CAPACITY)-1:0]    hit_idx_in,
    input  logic [$clog2(CAPACITY+1)-1:0]  count,
    input  logic [$clog2(CAPACITY)-1:0]    fetch_idx,
    input  logic                           wr_en,
    input  logic [$clog2(CAPACITY)-1:0]    wr_idx,
    input  logic [rst_pkg::WORD_W-1:0]     wr_data,
    output rst_pkg::tok_t                  tok_out,
    output logic [$clog2(CAPACITY)-1:0]    hit_idx_out
);
    import rst_pkg::*;

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic [WORD_W-1:0] entry_reg;
    tok_t              tok_reg;
    tok_t              tok_next;
    logic [IDX_W-1:0]  hit_idx_reg;
    logic [IDX_W-1:0]  hit_idx_next;
    logic              held;
    logic              match;

    assign held  = CNT_W'(IDX) < count;
    assign match = tok_in.vld && held && !tok_in.hit && (entry_reg == tok_in.key);

    always_comb
    begin
        tok_next     = tok_in;
        hit_idx_next = hit_idx_in;
        if (match)
        begin
            tok_next.hit = 1'b1;
            hit_idx_next = IDX_W'(IDX);
        end
        if (tok_in.vld && fetch_idx == IDX_W'(IDX))
        begin
            tok_next.data = entry_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en && wr_idx == IDX_W'(IDX))
        begin
            entry_reg <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg     <= '0;
            hit_idx_reg <= '0;
        end
        else
        begin
            tok_reg     <= tok_next;
            hit_idx_reg <= hit_idx_next;
        end
    end

    assign tok_out     = tok_reg;
    assign hit_idx_out = hit_idx_reg;

endmodule

>>> design/rst_mod.sv
// Bit-serial restoring remainder: random word modulo element count.
// Depends on rst_pkg; one quotient bit per cycle.
module rst_mod #(
    parameter int CAPACITY = 64
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [rst_pkg::WORD_W-1:0]     dividend,
    input  logic [$clog2(CAPACITY+1)-1:0]  divisor,
    output logic                           done,
    output logic [$clog2(CAPACITY)-1:0]    rem
);
    import rst_pkg::*;

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic              busy_reg;
    logic              done_reg;
    logic [STEP_W-1:0] step_reg;
    logic [WORD_W-1:0] quo_reg;
    logic [CNT_W-1:0]  rem_reg;
    logic [CNT_W-1:0]  div_reg;
    logic [CNT_W:0]    trial;
    logic [CNT_W:0]    diff;
    logic [CNT_W-1:0]  rem_next;

    assign trial    = {rem_reg, quo_reg[WORD_W-1]};
    assign diff     = trial - {1'b0, div_reg};
    assign rem_next = (trial >= {1'b0, div_reg}) ? diff[CNT_W-1:0] : trial[CNT_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(WORD_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            div_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[WORD_W-2:0], 1'b0};
            rem_reg <= rem_next;
        end
    end

    assign done = done_reg;
    assign rem  = rem_reg[IDX_W-1:0];

endmodule

>>> design/randomized_set_table_core.sv
// Randomized set table top level: request sequencer, cell chain, remainder unit.
// Depends on rst_pkg, rst_cell, rst_mod.
//
// Holds up to CAPACITY distinct 32-bit values in a chain of CAPACITY cells. Insert and
// remove send one search token down the chain, one cell per cycle. Get-random first
// reduces random_word modulo the count in a bit-serial unit and then sends a fetch
// token down the chain. Get-random on an empty set and the unused request code answer
// without a pass down the chain. One request is worked at a time; a new one is taken
// while the previous response still waits in the output register.
module randomized_set_table_core #(
    parameter int CAPACITY = 64
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  req_valid,
    output logic                                  req_stall,
    input  logic [rst_pkg::REQ_W-1:0]             req_type,
    input  logic signed [rst_pkg::WORD_W-1:0]     value,
    input  logic [rst_pkg::WORD_W-1:0]            random_word,
    output logic                                  rsp_valid,
    input  logic                                  rsp_stall,
    output logic [rst_pkg::ST_W-1:0]              status,
    output logic signed [rst_pkg::WORD_W-1:0]     picked_value,
    output logic [$clog2(CAPACITY+1)-1:0]         element_count
);
    import rst_pkg::*;

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);

    typedef enum logic [1:0] {S_IDLE, S_DIV, S_SCAN, S_DONE} state_t;

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [REQ_W-1:0]  type_reg, type_next;
    logic [WORD_W-1:0] key_reg, key_next;
    logic              launch_reg, launch_next;
    logic [ST_W-1:0]   res_status_reg, res_status_next;
    logic [WORD_W-1:0] res_pick_reg, res_pick_next;
    logic              rsp_valid_reg, rsp_valid_next;
    logic [ST_W-1:0]   status_reg;
    logic [WORD_W-1:0] pick_reg;
    logic [CNT_W-1:0]  count_out_reg;
    logic              load_rsp;

    logic              mod_start;
    logic              mod_done;
    logic [IDX_W-1:0]  mod_rem;

    logic              wr_en;
    logic [IDX_W-1:0]  wr_idx;
    logic [WORD_W-1:0] wr_data;
    logic [IDX_W-1:0]  fetch_idx;

    tok_t              tok_chain [0:CAPACITY];
    logic [IDX_W-1:0]  hit_chain [0:CAPACITY];
    tok_t              tok_end;
    logic [IDX_W-1:0]  hit_idx_end;

    assign tok_chain[0].vld  = launch_reg;
    assign tok_chain[0].hit  = 1'b0;
    assign tok_chain[0].key  = key_reg;
    assign tok_chain[0].data = '0;
    assign hit_chain[0]      = '0;
    assign tok_end           = tok_chain[CAPACITY];
    assign hit_idx_end       = hit_chain[CAPACITY];

    assign fetch_idx = (type_reg == REQ_GET) ? mod_rem : IDX_W'(count_reg - CNT_W'(1));

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        rst_cell #(
            .CAPACITY (CAPACITY),
            .IDX      (i)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .tok_in      (tok_chain[i]),
            .hit_idx_in  (hit_chain[i]),
            .count       (count_reg),
            .fetch_idx   (fetch_idx),
            .wr_en       (wr_en),
            .wr_idx      (wr_idx),
            .wr_data     (wr_data),
            .tok_out     (tok_chain[i+1]),
            .hit_idx_out (hit_chain[i+1])
        );
    end

    rst_mod #(
        .CAPACITY (CAPACITY)
    ) u_mod (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (mod_start),
        .dividend (random_word),
        .divisor  (count_reg),
        .done     (mod_done),
        .rem      (mod_rem)
    );

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        type_next       = type_reg;
        key_next        = key_reg;
        launch_next     = 1'b0;
        res_status_next = res_status_reg;
        res_pick_next   = res_pick_reg;
        mod_start       = 1'b0;
        wr_en           = 1'b0;
        wr_idx          = hit_idx_end;
        wr_data         = tok_end.data;
        load_rsp        = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    type_next       = req_type;
                    key_next        = unsigned'(value);
                    res_status_next = ST_OK;
                    res_pick_next   = '0;
                    case (req_type)
                        REQ_INSERT, REQ_REMOVE:
                        begin
                            launch_next = 1'b1;
                            state_next  = S_SCAN;
                        end
                        REQ_GET:
                        begin
                            if (count_reg == '0)
                            begin
                                res_status_next = ST_EMPTY;
                                state_next      = S_DONE;
                            end
                            else
                            begin
                                mod_start  = 1'b1;
                                state_next = S_DIV;
                            end
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_DIV:
            begin
                if (mod_done)
                begin
                    launch_next = 1'b1;
                    state_next  = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (tok_end.vld)
                begin
                    state_next = S_DONE;
                    case (type_reg)
                        REQ_INSERT:
                        begin
                            if (tok_end.hit)
                            begin
                                res_status_next = ST_MISS;
                            end
                            else if (count_reg == CNT_W'(CAPACITY))
                            begin
                                res_status_next = ST_FULL;
                            end
                            else
                            begin
                                wr_en      = 1'b1;
                                wr_idx     = count_reg[IDX_W-1:0];
                                wr_data    = key_reg;
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        REQ_REMOVE:
                        begin
                            if (!tok_end.hit)
                            begin
                                res_status_next = ST_MISS;
                            end
                            else
                            begin
                                wr_en      = 1'b1;
                                count_next = count_reg - CNT_W'(1);
                            end
                        end
                        REQ_GET:
                        begin
                            res_pick_next = tok_end.data;
                        end
                        default:
                        begin
                            res_status_next = ST_OK;
                        end
                    endcase
                end
            end
            S_DONE:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    load_rsp   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        rsp_valid_next = load_rsp || (rsp_valid_reg && rsp_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            type_reg       <= '0;
            key_reg        <= '0;
            launch_reg     <= 1'b0;
            res_status_reg <= ST_OK;
            res_pick_reg   <= '0;
            rsp_valid_reg  <= 1'b0;
            status_reg     <= ST_OK;
            pick_reg       <= '0;
            count_out_reg  <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            type_reg       <= type_next;
            key_reg        <= key_next;
            launch_reg     <= launch_next;
            res_status_reg <= res_status_next;
            res_pick_reg   <= res_pick_next;
            rsp_valid_reg  <= rsp_valid_next;
            if (load_rsp)
            begin
                status_reg    <= res_status_reg;
                pick_reg      <= res_pick_reg;
                count_out_reg <= count_reg;
            end
        end
    end

    assign req_stall     = (state_reg != S_IDLE);
    assign rsp_valid     = rsp_valid_reg;
    assign status        = status_reg;
    assign picked_value  = signed'(pick_reg);
    assign element_count = count_out_reg;

endmodule

>>> design/rst_chk.sv
// Port-level checker for randomized_set_table_core, with its bind.
// Depends on rst_pkg and randomized_set_table_core_assert.svh.
`include "randomized_set_table_core_assert.svh"

module rst_chk #(
    parameter int CAPACITY = 64
) (
    input logic                                  clk,
    input logic                                  rst_n,
    input logic                                  rsp_valid,
    input logic                                  rsp_stall,
    input logic [rst_pkg::ST_W-1:0]              status,
    input logic signed [rst_pkg::WORD_W-1:0]     picked_value,
    input logic [$clog2(CAPACITY+1)-1:0]         element_count
);
    import rst_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);

    `RST_ASSERT_IMP(a_count_range, rsp_valid, element_count <= CNT_W'(CAPACITY))
    `RST_ASSERT_IMP(a_pick_zero, rsp_valid && status != ST_OK, picked_value == '0)
    `RST_ASSERT_IMP(a_empty_count, rsp_valid && status == ST_EMPTY, element_count == '0)
    `RST_ASSERT_IMP(a_full_count, rsp_valid && status == ST_FULL,
                    element_count == CNT_W'(CAPACITY))
    `RST_ASSERT_NXT(a_rsp_hold, rsp_valid && rsp_stall,
                    rsp_valid && $stable(status) && $stable(picked_value))

endmodule

bind randomized_set_table_core rst_chk #(.CAPACITY(CAPACITY)) u_rst_chk (.*);

>>> verif/tb_randomized_set_table_core.sv
`timescale 1ns / 1ps
// Testbench for randomized_set_table_core: directed and random insert, remove and
// get-random requests checked beat by beat against an in-bench model of the set.
// Depends on rst_pkg and the block's RTL only.
module tb_randomized_set_table_core;
    import rst_pkg::*;

    localparam int SET_CAP = 64;
    localparam int CNT_W = $clog2(SET_CAP + 1);
    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
    localparam int POOL_N = 80;
    localparam int TAIL_CYCLES = 200;

    typedef struct {
        logic              pause;
        logic [REQ_W-1:0]  kind;
        logic [WORD_W-1:0] val;
        logic [WORD_W-1:0] rw;
    } set_req_t;

    typedef struct {
        logic [ST_W-1:0]   st;
        logic [WORD_W-1:0] pick;
        logic [CNT_W-1:0]  cnt;
    } set_rsp_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic req_stall;
    logic [REQ_W-1:0] req_type = '0;
    logic signed [WORD_W-1:0] value = '0;
    logic [WORD_W-1:0] random_word = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    logic [ST_W-1:0] status;
    logic signed [WORD_W-1:0] picked_value;
    logic [CNT_W-1:0] element_count;

    set_req_t req_q[$];
    set_rsp_t rsp_q[$];
    logic [WORD_W-1:0] held_vals [SET_CAP];
    int unsigned held = 0;
    logic [WORD_W-1:0] pool [POOL_N];
    int errors = 0;
    int beats_in = 0;
    int beats_out = 0;

    randomized_set_table_core #(.CAPACITY(SET_CAP)) u_top (
        .clk(clk),
        .rst_n(rst_n),
        .req_valid(req_valid),
        .req_stall(req_stall),
        .req_type(req_type),
        .value(value),
        .random_word(random_word),
        .rsp_valid(rsp_valid),
        .rsp_stall(rsp_stall),
        .status(status),
        .picked_value(picked_value),
        .element_count(element_count)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int unsigned find_slot(input logic [WORD_W-1:0] v);
        for (int unsigned i = 0; i < held; i++)
        begin
            if (held_vals[i] == v)
                return i;
        end
        return held;
    endfunction

    function automatic set_rsp_t apply_request(input set_req_t r);
        set_rsp_t o;
        int unsigned slot;
        o.st = ST_OK;
        o.pick = '0;
        case (r.kind)
            REQ_INSERT:
            begin
                slot = find_slot(r.val);
                if (slot < held)
                    o.st = ST_MISS;
                else if (held >= SET_CAP)
                    o.st = ST_FULL;
                else
                begin
                    held_vals[held] = r.val;
                    held++;
                end
            end
            REQ_REMOVE:
            begin
                slot = find_slot(r.val);
                if (slot >= held)
                    o.st = ST_MISS;
                else
                begin
                    if (slot != held - 1)
                        held_vals[slot] = held_vals[held - 1];
                    held--;
                end
            end
            REQ_GET:
            begin
                if (held == 0)
                    o.st = ST_EMPTY;
                else
                    o.pick = held_vals[r.rw % held];
            end
            default: ;
        endcase
        o.cnt = held[CNT_W-1:0];
        return o;
    endfunction

    task automatic add_req(input logic [REQ_W-1:0] k, input logic [WORD_W-1:0] v,
                           input logic [WORD_W-1:0] rw);
        set_req_t r;
        r.pause = 1'b0;
        r.kind = k;
        r.val = v;
        r.rw = rw;
        req_q = {req_q, r};
    endtask

    task automatic add_pause();
        set_req_t r;
        r.pause = 1'b1;
        r.kind = REQ_UNUSED;
        r.val = '0;
        r.rw = '0;
        req_q = {req_q, r};
    endtask

    function automatic logic [WORD_W-1:0] rand_word();
        int unsigned d;
        d = $urandom_range(99);
        if (d < 10)
            return $urandom_range(200);
        else if (d < 13)
            return '1;
        return $urandom;
    endfunction

    // Request driver: takes the head of req_q; a pause entry waits for all results.
    always @(posedge clk)
    begin : drive_p
        logic free;
        logic nv;
        logic idle;
        set_req_t nxt;
        set_rsp_t exp_rsp;
        if (rst_n)
        begin
            if (req_valid && !req_stall)
            begin
                nxt.pause = 1'b0;
                nxt.kind = req_type;
                nxt.val = value;
                nxt.rw = random_word;
                exp_rsp = apply_request(nxt);
                rsp_q = {rsp_q, exp_rsp};
                beats_in++;
            end
            free = !(req_valid && req_stall);
            nv = req_valid && req_stall;
            if (free)
            begin
                if (req_q.size() > 0 && req_q[0].pause && rsp_q.size() == 0)
                    void'(req_q.pop_front());
                idle = !(beats_in >= 220 && beats_in < 300) && ($urandom_range(99) < 34);
                if (req_q.size() > 0 && !req_q[0].pause && !idle)
                begin
                    nxt = req_q.pop_front();
                    req_type <= nxt.kind;
                    value <= nxt.val;
                    random_word <= nxt.rw;
                    nv = 1'b1;
                end
            end
            req_valid <= nv;
        end
    end

    // Result monitor and receiver stall, with one long hold-off to back the block up.
    always @(posedge clk)
    begin : mon_p
        int hold_left;
        logic hold_done;
        logic ns;
        set_rsp_t e;
        if (rst_n)
        begin
            if (rsp_valid && !rsp_stall)
            begin
                beats_out++;
                if (rsp_q.size() == 0)
                begin
                    errors++;
                    $display("%0t: result beat with nothing expected: st=%0d pick=%h cnt=%0d",
                             $time, status, picked_value, element_count);
                end
                else
                begin
                    e = rsp_q.pop_front();
                    if (status !== e.st)
                    begin
                        errors++;
                        $display("%0t: status expected %0d actual %0d", $time, e.st, status);
                    end
                    if (picked_value !== e.pick)
                    begin
                        errors++;
                        $display("%0t: picked_value expected %h actual %h",
                                 $time, e.pick, picked_value);
                    end
                    if (element_count !== e.cnt)
                    begin
                        errors++;
                        $display("%0t: element_count expected %0d actual %0d",
                                 $time, e.cnt, element_count);
                    end
                end
            end
            if (hold_left > 0)
            begin
                hold_left--;
                ns = 1'b1;
            end
            else if (hold_done !== 1'b1 && beats_out >= 120)
            begin
                hold_done = 1'b1;
                hold_left = 400;
                ns = 1'b1;
            end
            else
                ns = !(beats_out >= 220 && beats_out < 300) && ($urandom_range(99) < 34);
            rsp_stall <= ns;
        end
    end

    initial
    begin
        #5_000_000;
        $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        int unsigned d;
        int seq;
        for (int i = 0; i < POOL_N; i++)
            pool[i] = $urandom;
        pool[0] = 32'h8000_0000;
        pool[1] = 32'h7FFF_FFFF;
        pool[2] = 32'hFFFF_FFFF;
        pool[3] = 32'h0000_0000;

        // directed
        add_req(REQ_GET, 32'h1234_5678, $urandom);
        add_req(REQ_REMOVE, 32'h0000_0005, '0);
        add_req(REQ_UNUSED, '1, '1);
        add_req(REQ_INSERT, 32'h8000_0000, '1);
        add_req(REQ_INSERT, 32'h7FFF_FFFF, '0);
        add_req(REQ_INSERT, 32'h0000_0000, $urandom);
        add_req(REQ_INSERT, 32'hFFFF_FFFF, $urandom);
        add_req(REQ_INSERT, 32'h8000_0000, $urandom);
        add_req(REQ_GET, $urandom, 32'h0000_0000);
        add_req(REQ_GET, $urandom, 32'hFFFF_FFFF);
        add_req(REQ_REMOVE, 32'h7FFF_FFFF, $urandom);
        add_req(REQ_GET, '0, 32'h0000_0001);
        add_req(REQ_REMOVE, 32'h0000_0000, $urandom);
        add_req(REQ_REMOVE, 32'h0000_0000, $urandom);
        add_req(REQ_INSERT, 32'h5555_AAAA, $urandom);
        add_req(REQ_GET, '1, 32'h8000_0000);
        add_req(REQ_UNUSED, 32'h8000_0000, 32'h8000_0000);
        add_req(REQ_REMOVE, 32'h5555_AAAA, $urandom);
        add_req(REQ_REMOVE, 32'h8000_0000, $urandom);
        add_req(REQ_REMOVE, 32'hFFFF_FFFF, $urandom);
        add_req(REQ_GET, $urandom, $urandom);
        add_pause();

        // fill past capacity
        seq = 0;
        for (int i = 0; i < 140; i++)
        begin
            d = $urandom_range(99);
            if (d < 75)
            begin
                add_req(REQ_INSERT, pool[seq % POOL_N], rand_word());
                seq++;
            end
            else if (d < 85)
                add_req(REQ_INSERT, pool[$urandom_range(POOL_N - 1)], rand_word());
            else if (d < 95)
                add_req(REQ_GET, $urandom, rand_word());
            else
                add_req(REQ_REMOVE, pool[$urandom_range(POOL_N - 1)], rand_word());
        end
        add_pause();

        // churn
        for (int i = 0; i < 100; i++)
        begin
            d = $urandom_range(99);
            if (d < 35)
                add_req(REQ_INSERT, pool[$urandom_range(POOL_N - 1)], rand_word());
            else if (d < 70)
                add_req(REQ_REMOVE, pool[$urandom_range(POOL_N - 1)], rand_word());
            else if (d < 95)
                add_req(REQ_GET, $urandom, rand_word());
            else if (d < 98)
                add_req(REQ_REMOVE, $urandom, rand_word());
            else
                add_req(REQ_UNUSED, $urandom, $urandom);
        end

        // drain to empty and beyond
        seq = 0;
        for (int i = 0; i < 120; i++)
        begin
            d = $urandom_range(99);
            if (d < 80)
            begin
                add_req(REQ_REMOVE, pool[seq % POOL_N], rand_word());
                seq++;
            end
            else if (d < 90)
                add_req(REQ_GET, $urandom, rand_word());
            else
                add_req(REQ_REMOVE, $urandom, rand_word());
        end

        for (int i = 0; i < 60; i++)
        begin
            if (i == 30)
                add_pause();
            d = $urandom_range(99);
            if (d < 45)
                add_req(REQ_INSERT, pool[$urandom_range(POOL_N - 1)], rand_word());
            else if (d < 65)
                add_req(REQ_REMOVE, pool[$urandom_range(POOL_N - 1)], rand_word());
            else if (d < 95)
                add_req(REQ_GET, $urandom, rand_word());
            else
                add_req(REQ_UNUSED, $urandom, $urandom);
        end

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        while (req_q.size() > 0 || req_valid || rsp_q.size() > 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
